// ===== rtl/summed_area_table_stream_macros.svh =====
// assertion helpers used by summed_area_table_stream.sv
`ifndef SUMMED_AREA_TABLE_STREAM_MACROS_SVH
`define SUMMED_AREA_TABLE_STREAM_MACROS_SVH

// same-cycle implication, held off while reset is low
`define SAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("summed area table check failed");

// next-cycle implication, held off while reset is low
`define SAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("summed area table check failed");

`endif

// ===== rtl/sat_pkg.sv =====
package sat_pkg;

    localparam int MAX_COLS_DEF    = 256;
    localparam int MAX_ROWS_DEF    = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int AREA_W     = 32;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_RESET  = 256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLS_IN_USE = 1'b0,
        REG_ROWS_IN_USE = 1'b1
    } t_cfg_reg;

    // position flags handed from the position counter to the datapath
    typedef struct packed {
        logic first_row;
        logic last_col;
        logic frame_end;
    } t_pos_flags;

endpackage

// ===== rtl/sat_ram.sv =====
module sat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sat_pos.sv =====
module sat_pos
    import sat_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    parameter int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_step,
    output logic [CW-1:0]         o_col,
    output t_pos_flags            o_flags
);

    localparam int CLW = ((CW > CFG_DATA_W) ? CW : CFG_DATA_W) + 1;
    localparam int RLW = ((RW > CFG_DATA_W) ? RW : CFG_DATA_W) + 1;
    localparam int COLS_RST_M1 = ((MAX_COLS < CFG_RESET) ? MAX_COLS : CFG_RESET) - 1;
    localparam int ROWS_RST_M1 = ((MAX_ROWS < CFG_RESET) ? MAX_ROWS : CFG_RESET) - 1;

    logic [CW-1:0] r_cols_m1, n_cols_m1;
    logic [RW-1:0] r_rows_m1, n_rows_m1;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [CLW-1:0] cols_ext, cols_lim;
    logic [RLW-1:0] rows_ext, rows_lim;
    logic last_col, last_row;

    // zero counts as one, anything above the maximum as the maximum
    always_comb begin
        cols_ext = CLW'(i_cfg_data);
        rows_ext = RLW'(i_cfg_data);
        if (cols_ext == '0) begin
            cols_lim = '0;
        end else if (cols_ext > CLW'(MAX_COLS)) begin
            cols_lim = CLW'(MAX_COLS - 1);
        end else begin
            cols_lim = cols_ext - CLW'(1);
        end
        if (rows_ext == '0) begin
            rows_lim = '0;
        end else if (rows_ext > RLW'(MAX_ROWS)) begin
            rows_lim = RLW'(MAX_ROWS - 1);
        end else begin
            rows_lim = rows_ext - RLW'(1);
        end
    end

    always_comb begin
        n_cols_m1 = r_cols_m1;
        n_rows_m1 = r_rows_m1;
        if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_COLS_IN_USE: n_cols_m1 = cols_lim[CW-1:0];
                REG_ROWS_IN_USE: n_rows_m1 = rows_lim[RW-1:0];
                default: ;
            endcase
        end
    end

    // a position at or past the limit counts as the last one
    assign last_col = (r_col >= r_cols_m1);
    assign last_row = (r_row >= r_rows_m1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_step) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_m1 <= CW'(COLS_RST_M1);
            r_rows_m1 <= RW'(ROWS_RST_M1);
            r_col     <= '0;
            r_row     <= '0;
        end else begin
            r_cols_m1 <= n_cols_m1;
            r_rows_m1 <= n_rows_m1;
            r_col     <= n_col;
            r_row     <= n_row;
        end
    end

    assign o_col             = r_col;
    assign o_flags.first_row = (r_row == '0);
    assign o_flags.last_col  = last_col;
    assign o_flags.frame_end = last_col && last_row;

endmodule

// ===== rtl/summed_area_table_stream.sv =====
// pipeline: the stage 1 registers (row sum, line store read), then the output register (add)
// throughput: one item per cycle while the output is not stalled, set by the line store's
//   one read port used in the accept cycle and its one write port used for the write-back
//   when stage 1 moves on; a write-back to the column read in the same cycle is forwarded
//   (one-column rows); reset (synchronous, active low) clears the pipeline, position and
//   row sum and sets both limits to 256 or the maximum if lower; the line store is not cleared
`include "summed_area_table_stream_macros.svh"

module summed_area_table_stream
    import sat_pkg::*;
#(
    parameter int MAX_COLS    = MAX_COLS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_TDATA_W-1:0] i_s_tdata,   // sample
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [AREA_W-1:0]     o_m_tdata,   // area_sum
    output logic                  o_m_tlast    // frame_end
);

    localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RS_W = (SAMPLE_BITS + $clog2(MAX_COLS) < AREA_W)
                          ? SAMPLE_BITS + $clog2(MAX_COLS) : AREA_W;

    logic             accept, out_load;
    logic [CW-1:0]    col;
    t_pos_flags       flags;

    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [RS_W-1:0]        sample_ext, row_sum;
    logic signed [RS_W-1:0]        r_row_sum;

    logic                   r_s1_valid;
    logic signed [RS_W-1:0] r_s1_sum;
    logic [CW-1:0]          r_s1_col;
    logic                   r_s1_first, r_s1_end;

    logic                r_fwd;
    logic [AREA_W-1:0]   r_fwd_data;
    logic [AREA_W-1:0]   ram_rdata, above, area;

    logic                r_out_valid;
    logic [AREA_W-1:0]   r_out_data;
    logic                r_out_last;

    assign out_load   = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || out_load;
    assign accept     = i_s_tvalid && o_s_tready;

    sat_pos #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (accept),
        .o_col      (col),
        .o_flags    (flags)
    );

    assign sample     = i_s_tdata[SAMPLE_BITS-1:0];
    assign sample_ext = RS_W'(sample);
    assign row_sum    = r_row_sum + sample_ext;

    // row sum restarts after the last column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_sum <= '0;
        end else if (accept) begin
            r_row_sum <= flags.last_col ? '0 : row_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sum   <= row_sum;
            r_s1_col   <= col;
            r_s1_first <= flags.first_row;
            r_s1_end   <= flags.frame_end;
            // write-back landing on the entry read in this cycle
            r_fwd      <= out_load && (r_s1_col == col);
            r_fwd_data <= area;
        end
    end

    sat_ram #(
        .WIDTH (AREA_W),
        .DEPTH (MAX_COLS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (out_load),
        .i_waddr (r_s1_col),
        .i_wdata (area),
        .i_re    (accept),
        .i_raddr (col),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_s1_first) begin
            above = '0;
        end else if (r_fwd) begin
            above = r_fwd_data;
        end else begin
            above = ram_rdata;
        end
        area = AREA_W'(r_s1_sum) + above;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= area;
            r_out_last <= r_s1_end;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    `SAT_ASSERT_NEXT(a_accept_fills_s1, i_clk, i_rst_n, accept, r_s1_valid)
    `SAT_ASSERT_NEXT(a_s1_holds, i_clk, i_rst_n, r_s1_valid && !out_load,
                     r_s1_valid && $stable(r_s1_sum) && $stable(r_s1_col))
    `SAT_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, out_load, o_m_tvalid)

endmodule
